// ===== rtl/wstf_pkg.sv =====
`timescale 1ns / 1ps

package wstf_pkg;

  // Frame status codes reported with frame_done
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LEN64   = 2'd1;
  localparam logic [1:0] ST_TOOLONG = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // Header constants
  localparam logic [3:0] OPC_TEXT      = 4'h1;
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
  localparam logic [7:0] CHAR_SPACE    = 8'd32;
  localparam logic [7:0] CHAR_TILDE    = 8'd126;
  localparam logic [7:0] CHAR_TAB      = 8'd9;
  localparam logic [7:0] CHAR_LF       = 8'd10;
  localparam logic [7:0] CHAR_CR       = 8'd13;

  // Reset value of the payload length limit
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd512;

  // One result item
  typedef struct packed {
    logic [6:0] text_char;
    logic       char_valid;
    logic       frame_done;
    logic [1:0] status;
  } out_item_t;

endpackage

// ===== rtl/wstf_ifs.sv =====
`timescale 1ns / 1ps

// Received byte channel
interface wstf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       timed_out;

  modport source (output valid, output rx_byte, output timed_out, input ready);
  modport sink   (input valid, input rx_byte, input timed_out, output ready);
endinterface

// Result channel
interface wstf_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] text_char;
  logic       char_valid;
  logic       frame_done;
  logic [1:0] status;

  modport source (output valid, output text_char, output char_valid,
                  output frame_done, output status, input ready);
  modport sink   (input valid, input text_char, input char_valid,
                  input frame_done, input status, output ready);
endinterface

// Configuration write channel (max_payload)
interface wstf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_payload;

  modport source (output valid, output max_payload, input ready);
  modport sink   (input valid, input max_payload, output ready);
endinterface

// ===== rtl/wstf_skid.sv =====
`timescale 1ns / 1ps

module wstf_skid
  import wstf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  out_item_t up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output out_item_t dn_data
);

  logic      main_valid_r;
  out_item_t main_r;
  logic      skid_valid_r;
  out_item_t skid_r;

  // Upstream only waits when the spare slot is taken
  assign up_ready = !skid_valid_r;
  assign dn_valid = main_valid_r;
  assign dn_data  = main_r;

  // Control: main slot refills from skid first, then from upstream
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (dn_ready || !main_valid_r) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= up_valid;
      end
    end else if (up_valid && !skid_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (dn_ready || !main_valid_r) begin
      main_r <= skid_valid_r ? skid_r : up_data;
    end else if (up_valid && !skid_valid_r) begin
      skid_r <= up_data;
    end
  end

  // No transfer is lost: a stalled main slot keeps its item
  a_main_hold: assert property (@(posedge clk) disable iff (!rst_n)
    main_valid_r && !dn_ready |=> main_valid_r && $stable(main_r))
    else $error("skid: stalled result changed");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid: spare slot full while main slot empty");

endmodule

// ===== rtl/websocket_text_frame_receiver_top.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   rx_byte[7:0], timed_out
// out_ch    out  valid/ready   text_char[6:0], char_valid, frame_done, status[1:0]
// cfg_ch    in   valid/ready   max_payload[15:0] (ready is always high)
//
// One byte per cycle: the frame state and the result are computed in one pass
// from the accepted byte and the state registers; the result lands in a
// two-entry output buffer.
// The result is registered in the output buffer before it reaches out_ch.
// Reset (rst_n low, synchronous) returns to awaiting a header, limit 512.
// in_ch stalls only when both output entries are held by out_ch back-pressure.
module websocket_text_frame_receiver_top
  import wstf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  wstf_in_if.sink    in_ch,
  wstf_out_if.source out_ch,
  wstf_cfg_if.sink   cfg_ch
);

  localparam logic [3:0] PH_HDR0    = 4'd0;
  localparam logic [3:0] PH_HDR1    = 4'd1;
  localparam logic [3:0] PH_EXTHI   = 4'd2;
  localparam logic [3:0] PH_EXTLO   = 4'd3;
  localparam logic [3:0] PH_MASK0   = 4'd4;
  localparam logic [3:0] PH_MASK1   = 4'd5;
  localparam logic [3:0] PH_MASK2   = 4'd6;
  localparam logic [3:0] PH_MASK3   = 4'd7;
  localparam logic [3:0] PH_PAYLOAD = 4'd8;

  logic [15:0] max_payload_r;
  logic [3:0]  phase_r,   phase_nxt;
  logic [3:0]  opcode_r,  opcode_nxt;
  logic        masked_r,  masked_nxt;
  logic [7:0]  ext_hi_r,  ext_hi_nxt;
  logic [15:0] len_r,     len_nxt;
  logic [15:0] seen_r,    seen_nxt;
  logic [7:0]  key_r [4];
  logic        key_we;

  logic        accept;
  logic        res_valid;
  out_item_t   res;
  logic        res_ready;
  out_item_t   out_data;

  logic [15:0] len_cand;
  logic        masked_cand;
  logic        too_long;
  logic [7:0]  plain;
  logic [15:0] seen_inc;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = res_ready;
  assign cfg_ch.ready = 1'b1;

  // Length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_ch.valid) begin
      max_payload_r <= cfg_ch.max_payload;
    end
  end

  // Length as known on the last length byte, and its check
  assign len_cand    = (phase_r == PH_EXTLO) ? {ext_hi_r, in_ch.rx_byte}
                                             : {9'd0, in_ch.rx_byte[6:0]};
  assign masked_cand = (phase_r == PH_HDR1) ? in_ch.rx_byte[7] : masked_r;
  assign too_long    = len_cand > max_payload_r;

  // Unmasked payload byte and running count
  assign plain    = in_ch.rx_byte ^ (masked_r ? key_r[seen_r[1:0]] : 8'd0);
  assign seen_inc = seen_r + 16'd1;

  // Frame sequencer and result build
  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    ext_hi_nxt = ext_hi_r;
    len_nxt    = len_r;
    seen_nxt   = seen_r;
    key_we     = 1'b0;
    res_valid  = 1'b0;
    res        = '0;
    if (accept) begin
      if (in_ch.timed_out) begin
        phase_nxt      = PH_HDR0;
        res_valid      = 1'b1;
        res.frame_done = 1'b1;
        res.status     = ST_TIMEOUT;
      end else begin
        case (phase_r)
          PH_HDR1, PH_EXTLO: begin
            if (phase_r == PH_HDR1 && in_ch.rx_byte[6:0] == LEN_CODE_EXT16) begin
              masked_nxt = in_ch.rx_byte[7];
              phase_nxt  = PH_EXTHI;
            end else if (phase_r == PH_HDR1 &&
                         in_ch.rx_byte[6:0] == LEN_CODE_EXT64) begin
              masked_nxt     = in_ch.rx_byte[7];
              phase_nxt      = PH_HDR0;
              res_valid      = 1'b1;
              res.frame_done = 1'b1;
              res.status     = ST_LEN64;
            end else begin
              masked_nxt = masked_cand;
              len_nxt    = len_cand;
              if (too_long) begin
                phase_nxt      = PH_HDR0;
                res_valid      = 1'b1;
                res.frame_done = 1'b1;
                res.status     = ST_TOOLONG;
              end else begin
                seen_nxt = '0;
                if (masked_cand) begin
                  phase_nxt = PH_MASK0;
                end else if (len_cand == 16'd0) begin
                  phase_nxt      = PH_HDR0;
                  res_valid      = 1'b1;
                  res.frame_done = 1'b1;
                  res.status     = ST_OK;
                end else begin
                  phase_nxt = PH_PAYLOAD;
                end
              end
            end
          end
          PH_EXTHI: begin
            ext_hi_nxt = in_ch.rx_byte;
            phase_nxt  = PH_EXTLO;
          end
          PH_MASK0, PH_MASK1, PH_MASK2: begin
            key_we    = 1'b1;
            phase_nxt = phase_r + 4'd1;
          end
          PH_MASK3: begin
            key_we = 1'b1;
            if (len_r == 16'd0) begin
              phase_nxt      = PH_HDR0;
              res_valid      = 1'b1;
              res.frame_done = 1'b1;
              res.status     = ST_OK;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            if (opcode_r == OPC_TEXT) begin
              if (plain inside {[CHAR_SPACE:CHAR_TILDE]}) begin
                res.text_char  = plain[6:0];
                res.char_valid = 1'b1;
              end else if (plain inside {CHAR_LF, CHAR_CR, CHAR_TAB}) begin
                res.text_char  = CHAR_SPACE[6:0];
                res.char_valid = 1'b1;
              end
            end
            seen_nxt       = seen_inc;
            res.frame_done = seen_inc >= len_r;
            res.status     = ST_OK;
            if (res.frame_done) begin
              phase_nxt = PH_HDR0;
            end
            res_valid = res.char_valid || res.frame_done;
          end
          default: begin
            // awaiting first header byte
            opcode_nxt = in_ch.rx_byte[3:0];
            phase_nxt  = PH_HDR1;
          end
        endcase
      end
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      opcode_r <= '0;
      masked_r <= 1'b0;
      ext_hi_r <= '0;
      len_r    <= '0;
      seen_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      masked_r <= masked_nxt;
      ext_hi_r <= ext_hi_nxt;
      len_r    <= len_nxt;
      seen_r   <= seen_nxt;
    end
  end

  // Mask key bytes, indexed by mask phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
    end else if (key_we) begin
      key_r[phase_r[1:0]] <= in_ch.rx_byte;
    end
  end

  // Output buffer
  wstf_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (res_valid),
    .up_ready (res_ready),
    .up_data  (res),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_data  (out_data)
  );

  assign out_ch.text_char  = out_data.text_char;
  assign out_ch.char_valid = out_data.char_valid;
  assign out_ch.frame_done = out_data.frame_done;
  assign out_ch.status     = out_data.status;

  // A timeout always abandons the frame
  a_timeout_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.timed_out |=> phase_r == PH_HDR0)
    else $error("timeout did not return to header");

  // Inside the payload phase the count stays below the frame length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> seen_r < len_r)
    else $error("payload count reached length inside payload");

  // Error status only on a frame end, char only when kept
  a_res_shape: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res.status == ST_OK || res.frame_done) &&
                  (res.char_valid || res.text_char == 7'd0))
    else $error("malformed result");

  // Results are only made from accepted bytes
  a_res_accept: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> accept)
    else $error("result without a byte transfer");

endmodule

// ===== test/tb_websocket_text_frame_receiver_top.sv =====
`timescale 1ns / 1ps

module tb_websocket_text_frame_receiver_top;
  import wstf_pkg::*;

  // Non-text opcode used by the directed frames
  localparam logic [3:0] OPC_BINARY = 4'h2;

  // Deframer phases, numbered as in the block
  typedef enum logic [3:0] {
    WAIT_OPCODE = 4'd0,
    WAIT_LEN    = 4'd1,
    WAIT_EXT_HI = 4'd2,
    WAIT_EXT_LO = 4'd3,
    WAIT_KEY0   = 4'd4,
    WAIT_KEY1   = 4'd5,
    WAIT_KEY2   = 4'd6,
    WAIT_KEY3   = 4'd7,
    IN_PAYLOAD  = 4'd8
  } deframe_phase_e;

  typedef struct {
    logic [7:0] rx_byte;
    logic       timed_out;
  } rx_item_t;

  logic clk = 1'b0;
  logic rst_n;

  wstf_in_if  in_ch ();
  wstf_out_if out_ch ();
  wstf_cfg_if cfg_ch ();

  websocket_text_frame_receiver_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  // Stimulus bytes waiting to be sent, and characters/status still due
  rx_item_t    rx_bytes_q [$];
  out_item_t   due_chars_q [$];
  int unsigned err_count = 0;
  int unsigned byte_count = 0;

  // Predictor state
  deframe_phase_e fr_phase;
  logic [3:0]     fr_opcode;
  logic           fr_masked;
  logic [7:0]     fr_len_hi;
  logic [15:0]    fr_len;
  logic [15:0]    fr_count;
  logic [7:0]     fr_key [4];
  logic [15:0]    len_limit;

  // Driver / responder state
  logic        byte_sent;
  rx_item_t    next_rx;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  // Stimulus-side copy of the limit and the sequence of limits
  logic [15:0] gen_limit;
  logic [15:0] limit_plan [6];

  task automatic report_err(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Mostly short gaps, occasionally a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Length is known: range check and pick the next phase
  function automatic bit length_known(output out_item_t res);
    res = '0;
    if (fr_len > len_limit) begin
      fr_phase = WAIT_OPCODE;
      res.frame_done = 1'b1;
      res.status = ST_TOOLONG;
      return 1'b1;
    end
    fr_count = '0;
    if (fr_masked) begin
      fr_phase = WAIT_KEY0;
      return 1'b0;
    end
    if (fr_len == 0) begin
      fr_phase = WAIT_OPCODE;
      res.frame_done = 1'b1;
      res.status = ST_OK;
      return 1'b1;
    end
    fr_phase = IN_PAYLOAD;
    return 1'b0;
  endfunction

  // Advance the frame state by one received byte; returns 1 if a result is due
  function automatic bit deframe_byte(input logic [7:0] rx, input logic tmo,
                                      output out_item_t res);
    logic [7:0] b;
    logic [6:0] code;
    res = '0;
    b = rx;
    if (tmo) begin
      fr_phase = WAIT_OPCODE;
      res.frame_done = 1'b1;
      res.status = ST_TIMEOUT;
      return 1'b1;
    end
    case (fr_phase)
      WAIT_LEN: begin
        fr_masked = b[7];
        code = b[6:0];
        if (code == LEN_CODE_EXT16) begin
          fr_phase = WAIT_EXT_HI;
          return 1'b0;
        end
        if (code == LEN_CODE_EXT64) begin
          fr_phase = WAIT_OPCODE;
          res.frame_done = 1'b1;
          res.status = ST_LEN64;
          return 1'b1;
        end
        fr_len = {9'd0, code};
        return length_known(res);
      end
      WAIT_EXT_HI: begin
        fr_len_hi = b;
        fr_phase = WAIT_EXT_LO;
        return 1'b0;
      end
      WAIT_EXT_LO: begin
        fr_len = {fr_len_hi, b};
        return length_known(res);
      end
      WAIT_KEY0, WAIT_KEY1, WAIT_KEY2, WAIT_KEY3: begin
        fr_key[fr_phase[1:0]] = b;
        if (fr_phase != WAIT_KEY3) begin
          fr_phase = deframe_phase_e'(fr_phase + 4'd1);
          return 1'b0;
        end
        if (fr_len == 0) begin
          fr_phase = WAIT_OPCODE;
          res.frame_done = 1'b1;
          res.status = ST_OK;
          return 1'b1;
        end
        fr_phase = IN_PAYLOAD;
        return 1'b0;
      end
      IN_PAYLOAD: begin
        if (fr_masked) b = b ^ fr_key[fr_count[1:0]];
        if (fr_opcode == OPC_TEXT) begin
          if (b >= CHAR_SPACE && b <= CHAR_TILDE) begin
            res.text_char = b[6:0];
            res.char_valid = 1'b1;
          end else if (b == CHAR_LF || b == CHAR_CR || b == CHAR_TAB) begin
            res.text_char = CHAR_SPACE[6:0];
            res.char_valid = 1'b1;
          end
        end
        fr_count = fr_count + 16'd1;
        if (fr_count >= fr_len) begin
          res.frame_done = 1'b1;
          fr_phase = WAIT_OPCODE;
        end
        return res.char_valid || res.frame_done;
      end
      default: begin
        // first header byte
        fr_opcode = b[3:0];
        fr_phase = WAIT_LEN;
        return 1'b0;
      end
    endcase
  endfunction

  // Predict on each byte transfer, check each result transfer
  always @(posedge clk) begin
    out_item_t res;
    out_item_t want;
    if (!rst_n) begin
      fr_phase  = WAIT_OPCODE;
      fr_opcode = '0;
      fr_masked = 1'b0;
      fr_len_hi = '0;
      fr_len    = '0;
      fr_count  = '0;
      for (int i = 0; i < 4; i++) fr_key[i] = '0;
      len_limit = MAX_PAYLOAD_RST;
      byte_sent <= 1'b0;
    end else begin
      byte_sent <= in_ch.valid && in_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) len_limit = cfg_ch.max_payload;
      if (in_ch.valid && in_ch.ready) begin
        if (deframe_byte(in_ch.rx_byte, in_ch.timed_out, res)) due_chars_q.push_back(res);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (due_chars_q.size() == 0) begin
          report_err($sformatf("unexpected result char=%0d valid=%0b done=%0b status=%0d",
                               out_ch.text_char, out_ch.char_valid, out_ch.frame_done,
                               out_ch.status));
        end else begin
          want = due_chars_q.pop_front();
          if (out_ch.text_char !== want.text_char)
            report_err($sformatf("text_char got %0d want %0d",
                                 out_ch.text_char, want.text_char));
          if (out_ch.char_valid !== want.char_valid)
            report_err($sformatf("char_valid got %0b want %0b",
                                 out_ch.char_valid, want.char_valid));
          if (out_ch.frame_done !== want.frame_done)
            report_err($sformatf("frame_done got %0b want %0b",
                                 out_ch.frame_done, want.frame_done));
          if (out_ch.status !== want.status)
            report_err($sformatf("status got %0d want %0d", out_ch.status, want.status));
        end
      end
    end
  end

  // Byte driver: holds a byte until its transfer, then idles or sends the next
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || byte_sent) begin
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (rx_bytes_q.size() > 0) begin
        next_rx = rx_bytes_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.rx_byte   <= next_rx.rx_byte;
        in_ch.timed_out <= next_rx.timed_out;
        in_gap <= in_calm ? 0 : idle_len();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    if ($urandom_range(0, 299) == 0) in_calm <= !in_calm;
  end

  // Result back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!out_calm && $urandom_range(0, 3) == 0) out_stall <= idle_len();
    end
    if ($urandom_range(0, 299) == 0) out_calm <= !out_calm;
  end

  task automatic push_byte(input logic [7:0] b, input logic tmo);
    rx_item_t it;
    it.rx_byte = b;
    it.timed_out = tmo;
    rx_bytes_q.push_back(it);
    byte_count++;
  endtask

  task automatic push_timeout();
    push_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // One random frame; mostly well-formed, sometimes noise or cut short
  task automatic add_frame();
    int unsigned r;
    int unsigned plen;
    int unsigned cut;
    logic [15:0] len16;
    logic [3:0]  opc;
    logic [7:0]  key [4];
    logic [7:0]  ch;
    bit          masked;
    bit          ext;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      repeat ($urandom_range(1, 6))
        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
      push_timeout();
      return;
    end
    opc = ($urandom_range(0, 9) < 7) ? OPC_TEXT : 4'($urandom_range(0, 15));
    masked = $urandom_range(0, 1);
    push_byte({4'($urandom_range(0, 15)), opc}, 1'b0);
    r = $urandom_range(0, 99);
    if (r < 3) begin
      push_byte({masked, LEN_CODE_EXT64}, 1'b0);
      return;
    end
    if (r < 70) begin
      plen = $urandom_range(0, 20);
    end else if (r < 85) begin
      plen = $urandom_range(0, 40);
    end else begin
      // just below, at and just above the limit
      plen = gen_limit + $urandom_range(0, 2);
      if (plen > 0) plen = plen - 1;
      if (plen > 65535) plen = 65535;
    end
    len16 = plen[15:0];
    ext = (plen > 125) || (r >= 70 && r < 85) || ($urandom_range(0, 9) == 0);
    push_byte({masked, ext ? LEN_CODE_EXT16 : len16[6:0]}, 1'b0);
    if (ext) begin
      push_byte(len16[15:8], 1'b0);
      push_byte(len16[7:0], 1'b0);
    end
    if (plen > gen_limit) return;
    if (masked) begin
      for (int i = 0; i < 4; i++) begin
        key[i] = 8'($urandom_range(0, 255));
        push_byte(key[i], 1'b0);
      end
    end
    // long frames, and now and then shorter ones, are cut short by a timeout
    cut = plen;
    if (plen > 600) cut = $urandom_range(1, 30);
    else if (plen > 0 && $urandom_range(0, 19) == 0) cut = $urandom_range(0, plen - 1);
    for (int i = 0; i < cut; i++) begin
      r = $urandom_range(0, 99);
      if (r < 65) ch = 8'($urandom_range(32, 126));
      else if (r < 70) ch = CHAR_TAB;
      else if (r < 75) ch = CHAR_LF;
      else if (r < 80) ch = CHAR_CR;
      else ch = 8'($urandom_range(0, 255));
      if (masked) ch = ch ^ key[i % 4];
      push_byte(ch, 1'b0);
    end
    if (cut < plen) push_timeout();
  endtask

  task automatic add_frames(input int unsigned n);
    int unsigned start;
    start = byte_count;
    while (byte_count - start < n) add_frame();
  endtask

  // Wait until every byte is sent and every result has come back
  task automatic drain();
    do @(negedge clk);
    while (rx_bytes_q.size() != 0 || in_ch.valid || due_chars_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.max_payload <= v;
    do @(posedge clk);
    while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    gen_limit = v;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    in_ch.timed_out = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_payload = '0;
    gen_limit = MAX_PAYLOAD_RST;
    limit_plan[0] = 16'd0;
    limit_plan[1] = 16'd65535;
    limit_plan[2] = 16'd126;
    limit_plan[3] = 16'd125;
    limit_plan[4] = 16'($urandom_range(1, 600));
    limit_plan[5] = MAX_PAYLOAD_RST;

    // Unmasked text: plain char, TAB/LF/CR as space, tilde on the last byte
    push_byte({4'h8, OPC_TEXT}, 1'b0);
    push_byte({1'b0, 7'd5}, 1'b0);
    push_byte(8'h48, 1'b0);
    push_byte(CHAR_TAB, 1'b0);
    push_byte(CHAR_LF, 1'b0);
    push_byte(CHAR_CR, 1'b0);
    push_byte(CHAR_TILDE, 1'b0);
    // 64-bit length code is rejected
    push_byte({4'h8, OPC_TEXT}, 1'b0);
    push_byte({1'b1, LEN_CODE_EXT64}, 1'b0);
    // 16-bit length 513 exceeds the reset limit
    push_byte({4'h8, OPC_TEXT}, 1'b0);
    push_byte({1'b0, LEN_CODE_EXT16}, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h01, 1'b0);
    // Masked empty binary frame ends on the last key byte
    push_byte({4'h8, OPC_BINARY}, 1'b0);
    push_byte({1'b1, 7'd0}, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hA5, 1'b0);
    // Timeout while idle, then timeout in mid payload
    push_timeout();
    push_byte({4'h0, OPC_TEXT}, 1'b0);
    push_byte({1'b0, 7'd3}, 1'b0);
    push_byte(8'h41, 1'b0);
    push_timeout();
    add_frames(250);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    drain();

    // Several limit settings, extremes first
    for (int p = 0; p < 6; p++) begin
      write_limit(limit_plan[p]);
      add_frames(290);
      drain();
    end

    repeat (10) @(negedge clk);
    if (due_chars_q.size() != 0)
      report_err($sformatf("%0d results never arrived", due_chars_q.size()));
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== websocket_text_frame_receiver_top.f =====
rtl/wstf_pkg.sv
rtl/wstf_ifs.sv
rtl/wstf_skid.sv
rtl/websocket_text_frame_receiver_top.sv
test/tb_websocket_text_frame_receiver_top.sv
